### rtl/cpc_pkg.sv
// shared types, codes and defaults of the convex polygon clipper
package cpc_pkg;

   localparam int MAX_SUBJECT_DEF = 16;
   localparam int MAX_CLIP_DEF    = 16;
   localparam int MAX_OUTPUT_DEF  = 32;
   localparam int COORD_WIDTH_DEF = 32;
   localparam int RESULT_LIMIT    = 32;

   typedef enum logic [1:0] {
      CMD_LOAD_SUBJECT = 2'd0,
      CMD_LOAD_CLIP    = 2'd1,
      CMD_RUN          = 2'd2,
      CMD_CLEAR        = 2'd3
   } cmd_type;

   localparam logic [1:0] STATUS_VALID    = 2'd0;
   localparam logic [1:0] STATUS_EMPTY    = 2'd1;
   localparam logic [1:0] STATUS_OVERFLOW = 2'd2;

   typedef struct packed {
      cmd_type            command;
      logic signed [31:0] coord_x;
      logic signed [31:0] coord_y;
   } req_type;

   typedef struct packed {
      logic signed [31:0] out_x;
      logic signed [31:0] out_y;
      logic               last_vertex;
      logic [1:0]         status;
   } rsp_type;

   typedef enum logic {
      ALU_MUL  = 1'b0,
      ALU_LERP = 1'b1
   } alu_op_type;

   typedef struct packed {
      logic       start;
      alu_op_type op;
   } alu_ctl_type;

   typedef struct packed {
      logic busy;
      logic done;
   } alu_stat_type;

endpackage

### rtl/convex_polygon_clipper_unit.sv
// top level of the convex polygon clipper: command decode, run sequencer, result output
//
//  channel   dir  ports                       moves
//  request   in   req_valid/req_stall/req_data  command item with one vertex
//  response  out  rsp_valid/rsp_stall/rsp_data  clipped vertex or status item
//
// loads and clears are taken while idle; a run is sequenced over the shared alu, one
// vertex at a time: each multiply or divide is started, steps through its bits and
// signals done, a side test is two multiplies and a crossing two divides, and each
// vertex is then pushed, copied or emitted as an item.
// req_stall stays high for the whole run until the last result item is taken.
// synchronous reset clears the counts and the sequencer; rsp_stall holds the item.
module convex_polygon_clipper_unit #(
   parameter int MAX_SUBJECT = cpc_pkg::MAX_SUBJECT_DEF,
   parameter int MAX_CLIP    = cpc_pkg::MAX_CLIP_DEF,
   parameter int MAX_OUTPUT  = cpc_pkg::MAX_OUTPUT_DEF,
   parameter int COORD_WIDTH = cpc_pkg::COORD_WIDTH_DEF
) (
   input  logic              clock,
   input  logic              reset,
   input  logic              req_valid,
   output logic              req_stall,
   input  cpc_pkg::req_type  req_data,
   output logic              rsp_valid,
   input  logic              rsp_stall,
   output cpc_pkg::rsp_type  rsp_data
);

   localparam int CW  = COORD_WIDTH;
   localparam int DW  = CW + 1;          // coordinate differences
   localparam int PW  = 2 * DW;          // products
   localparam int SW  = PW + 1;          // cross products
   localparam int NW  = SW + 1;          // divider operands
   localparam int SAW = $clog2(MAX_SUBJECT);
   localparam int CAW = $clog2(MAX_CLIP);
   localparam int OW  = $clog2(MAX_OUTPUT);
   localparam int SCW = $clog2(MAX_SUBJECT + 1);
   localparam int CCW = $clog2(MAX_CLIP + 1);
   localparam int NCW = $clog2(MAX_OUTPUT + 1);
   localparam int IW  = (SCW > NCW) ? SCW : NCW;
   localparam int WORK_DEPTH = 2 * (2 ** OW);

   localparam logic signed [63:0] C_HI = (64'sd1 <<< (CW - 1)) - 64'sd1;
   localparam logic signed [63:0] C_LO = -C_HI - 64'sd1;
   localparam logic signed [63:0] O_HI = 64'sd2147483647;
   localparam logic signed [63:0] O_LO = -O_HI - 64'sd1;

   typedef enum logic [4:0] {
      ST_IDLE, ST_COPY_RD, ST_COPY_GET, ST_EDGE_S, ST_EDGE_E, ST_EDGE_SETUP,
      ST_PREV_GET, ST_CUR_RD, ST_CUR_GET, ST_M1_GO, ST_M1_WAIT, ST_M2_GO,
      ST_M2_WAIT, ST_DECIDE, ST_LX_GO, ST_LX_WAIT, ST_LY_GO, ST_LY_WAIT,
      ST_PUSH_CROSS, ST_PUSH_CUR, ST_NEXT, ST_EMIT_START, ST_EMIT_RD,
      ST_EMIT_GET, ST_EMIT_OUT
   } state_type;

   function automatic logic signed [CW-1:0] sat_in(logic signed [31:0] v);
      logic signed [63:0] w;
      w = 64'(v);
      if (w > C_HI) w = C_HI;
      if (w < C_LO) w = C_LO;
      return w[CW-1:0];
   endfunction

   function automatic logic signed [31:0] sat_out(logic signed [CW-1:0] v);
      logic signed [63:0] w;
      w = 64'(v);
      if (w > O_HI) w = O_HI;
      if (w < O_LO) w = O_LO;
      return w[31:0];
   endfunction

   state_type             state_ff, state_in;
   logic [SCW-1:0]        sc_ff, sc_in;       // subject vertex count
   logic [CCW-1:0]        cc_ff, cc_in;       // clip vertex count
   logic [NCW-1:0]        n_ff, n_in;         // vertices in source list
   logic [NCW-1:0]        m_ff, m_in;         // vertices pushed this pass
   logic [IW-1:0]         i_ff, i_in;
   logic [CCW-1:0]        j_ff, j_in;         // clip edge
   logic                  bank_ff, bank_in;   // source half of work memory
   logic                  ovf_ff, ovf_in;
   logic                  side_cur_ff, side_cur_in;
   logic signed [CW-1:0]  s_x_ff, s_x_in, s_y_ff, s_y_in;
   logic signed [DW-1:0]  ex_ff, ex_in, ey_ff, ey_in;
   logic signed [CW-1:0]  prev_x_ff, prev_x_in, prev_y_ff, prev_y_in;
   logic signed [CW-1:0]  cur_x_ff, cur_x_in, cur_y_ff, cur_y_in;
   logic signed [DW-1:0]  pxd_ff, pxd_in, pyd_ff, pyd_in;
   logic signed [PW-1:0]  p1_ff, p1_in;
   logic signed [SW-1:0]  sp_ff, sp_in, sc_side_ff, sc_side_in;
   logic [NW-1:0]         num_ff, num_in, den_ff, den_in;
   logic signed [CW-1:0]  cross_x_ff, cross_x_in, cross_y_ff, cross_y_in;
   cpc_pkg::rsp_type      rsp_ff, rsp_in;

   // memories
   logic                  subj_we, clip_we, work_we;
   logic [SAW-1:0]        subj_wa, subj_ra;
   logic [CAW-1:0]        clip_wa, clip_ra;
   logic [OW:0]           work_wa, work_ra;
   logic [2*CW-1:0]       load_vtx, work_wd;
   logic [2*CW-1:0]       subj_rd, clip_rd, work_rd;

   // shared alu
   cpc_pkg::alu_ctl_type  alu_ctl;
   cpc_pkg::alu_stat_type alu_stat;
   logic signed [DW-1:0]  alu_a, alu_b;
   logic signed [CW-1:0]  alu_base;
   logic signed [PW-1:0]  alu_prod;
   logic signed [CW-1:0]  alu_coord;

   logic signed [CW-1:0]  clip_x, clip_y, wrk_x, wrk_y;
   logic signed [SW-1:0]  side_val;
   logic signed [SW:0]    side_diff;
   logic [SW-1:0]         sp_mag;
   logic                  cur_in, prev_in;
   logic [NCW-1:0]        n_m1;
   logic [CCW-1:0]        j_nx;
   logic                  accept;
   logic                  more_than_limit;
   logic [31:0]           emit_k;

   assign accept   = req_valid && !req_stall;
   assign load_vtx = {sat_in(req_data.coord_y), sat_in(req_data.coord_x)};

   assign clip_x = clip_rd[CW-1:0];
   assign clip_y = clip_rd[2*CW-1:CW];
   assign wrk_x  = work_rd[CW-1:0];
   assign wrk_y  = work_rd[2*CW-1:CW];

   // inside means left of or on the edge
   assign cur_in  = !sc_side_ff[SW-1];
   assign prev_in = !sp_ff[SW-1];
   assign side_val  = SW'(p1_ff) - SW'(alu_prod);
   assign side_diff = (SW+1)'(sp_ff) - (SW+1)'(sc_side_ff);
   assign sp_mag    = sp_ff[SW-1] ? SW'(-sp_ff) : SW'(sp_ff);

   assign n_m1 = n_ff - NCW'(1);
   assign j_nx = (32'(j_ff) + 32'd1 == 32'(cc_ff)) ? '0 : j_ff + CCW'(1);

   assign more_than_limit = 32'(n_ff) > cpc_pkg::RESULT_LIMIT;
   assign emit_k = more_than_limit ? cpc_pkg::RESULT_LIMIT : 32'(n_ff);

   // memory ports
   always_comb begin
      subj_we = accept && (req_data.command == cpc_pkg::CMD_LOAD_SUBJECT) &&
                (32'(sc_ff) < MAX_SUBJECT);
      clip_we = accept && (req_data.command == cpc_pkg::CMD_LOAD_CLIP) &&
                (32'(cc_ff) < MAX_CLIP);
      subj_wa = sc_ff[SAW-1:0];
      clip_wa = cc_ff[CAW-1:0];
      subj_ra = i_ff[SAW-1:0];
      clip_ra = (state_ff == ST_EDGE_E) ? j_nx[CAW-1:0] : j_ff[CAW-1:0];

      work_we = 1'b0;
      work_wa = {~bank_ff, m_ff[OW-1:0]};
      work_wd = {cur_y_ff, cur_x_ff};
      unique case (state_ff)
         ST_COPY_GET: begin
            work_we = 32'(i_ff) < MAX_OUTPUT;
            work_wa = {bank_ff, i_ff[OW-1:0]};
            work_wd = subj_rd;
         end
         ST_PUSH_CROSS: begin
            work_we = 32'(m_ff) < MAX_OUTPUT;
            work_wd = {cross_y_ff, cross_x_ff};
         end
         ST_PUSH_CUR: begin
            work_we = 32'(m_ff) < MAX_OUTPUT;
         end
         default: ;
      endcase

      work_ra = (state_ff == ST_EDGE_SETUP) ? {bank_ff, n_m1[OW-1:0]}
                                            : {bank_ff, i_ff[OW-1:0]};
   end

   // alu operand selection
   always_comb begin
      alu_ctl.start = 1'b0;
      alu_ctl.op    = cpc_pkg::ALU_MUL;
      alu_a         = ex_ff;
      alu_b         = pyd_ff;
      alu_base      = prev_x_ff;
      unique case (state_ff)
         ST_M1_GO: begin
            alu_ctl.start = 1'b1;
         end
         ST_M2_GO: begin
            alu_ctl.start = 1'b1;
            alu_a         = ey_ff;
            alu_b         = pxd_ff;
         end
         ST_LX_GO: begin
            alu_ctl.start = 1'b1;
            alu_ctl.op    = cpc_pkg::ALU_LERP;
            alu_a         = DW'(cur_x_ff) - DW'(prev_x_ff);
         end
         ST_LY_GO: begin
            alu_ctl.start = 1'b1;
            alu_ctl.op    = cpc_pkg::ALU_LERP;
            alu_a         = DW'(cur_y_ff) - DW'(prev_y_ff);
            alu_base      = prev_y_ff;
         end
         default: ;
      endcase
   end

   // run sequencer
   always_comb begin
      state_in    = state_ff;
      sc_in       = sc_ff;
      cc_in       = cc_ff;
      n_in        = n_ff;
      m_in        = m_ff;
      i_in        = i_ff;
      j_in        = j_ff;
      bank_in     = bank_ff;
      ovf_in      = ovf_ff;
      side_cur_in = side_cur_ff;
      s_x_in      = s_x_ff;
      s_y_in      = s_y_ff;
      ex_in       = ex_ff;
      ey_in       = ey_ff;
      prev_x_in   = prev_x_ff;
      prev_y_in   = prev_y_ff;
      cur_x_in    = cur_x_ff;
      cur_y_in    = cur_y_ff;
      pxd_in      = pxd_ff;
      pyd_in      = pyd_ff;
      p1_in       = p1_ff;
      sp_in       = sp_ff;
      sc_side_in  = sc_side_ff;
      num_in      = num_ff;
      den_in      = den_ff;
      cross_x_in  = cross_x_ff;
      cross_y_in  = cross_y_ff;
      rsp_in      = rsp_ff;

      unique case (state_ff)
         ST_IDLE: begin
            if (accept) begin
               unique case (req_data.command)
                  cpc_pkg::CMD_LOAD_SUBJECT: begin
                     if (subj_we) sc_in = sc_ff + SCW'(1);
                  end
                  cpc_pkg::CMD_LOAD_CLIP: begin
                     if (clip_we) cc_in = cc_ff + CCW'(1);
                  end
                  cpc_pkg::CMD_CLEAR: begin
                     sc_in = '0;
                     cc_in = '0;
                  end
                  cpc_pkg::CMD_RUN: begin
                     ovf_in  = 1'b0;
                     m_in    = '0;
                     bank_in = 1'b0;
                     i_in    = '0;
                     j_in    = '0;
                     if (sc_ff == '0 || cc_ff == '0) begin
                        n_in     = '0;
                        state_in = ST_EMIT_START;
                     end else begin
                        state_in = ST_COPY_RD;
                     end
                  end
                  default: ;
               endcase
            end
         end
         ST_COPY_RD: state_in = ST_COPY_GET;
         ST_COPY_GET: begin
            // subject vertices past the list size are dropped
            if (32'(i_ff) >= MAX_OUTPUT) ovf_in = 1'b1;
            if (32'(i_ff) + 32'd1 == 32'(sc_ff)) begin
               n_in = (32'(sc_ff) > MAX_OUTPUT) ? NCW'(MAX_OUTPUT) : NCW'(sc_ff);
               state_in = ST_EDGE_S;
            end else begin
               i_in     = i_ff + IW'(1);
               state_in = ST_COPY_RD;
            end
         end
         ST_EDGE_S: state_in = ST_EDGE_E;
         ST_EDGE_E: begin
            s_x_in   = clip_x;
            s_y_in   = clip_y;
            state_in = ST_EDGE_SETUP;
         end
         ST_EDGE_SETUP: begin
            ex_in    = DW'(clip_x) - DW'(s_x_ff);
            ey_in    = DW'(clip_y) - DW'(s_y_ff);
            m_in     = '0;
            state_in = ST_PREV_GET;
         end
         ST_PREV_GET: begin
            // last source vertex closes the polygon
            prev_x_in   = wrk_x;
            prev_y_in   = wrk_y;
            pxd_in      = DW'(wrk_x) - DW'(s_x_ff);
            pyd_in      = DW'(wrk_y) - DW'(s_y_ff);
            side_cur_in = 1'b0;
            state_in    = ST_M1_GO;
         end
         ST_CUR_RD: state_in = ST_CUR_GET;
         ST_CUR_GET: begin
            cur_x_in    = wrk_x;
            cur_y_in    = wrk_y;
            pxd_in      = DW'(wrk_x) - DW'(s_x_ff);
            pyd_in      = DW'(wrk_y) - DW'(s_y_ff);
            side_cur_in = 1'b1;
            state_in    = ST_M1_GO;
         end
         ST_M1_GO: state_in = ST_M1_WAIT;
         ST_M1_WAIT: begin
            if (alu_stat.done) begin
               p1_in    = alu_prod;
               state_in = ST_M2_GO;
            end
         end
         ST_M2_GO: state_in = ST_M2_WAIT;
         ST_M2_WAIT: begin
            if (alu_stat.done) begin
               if (side_cur_ff) begin
                  sc_side_in = side_val;
                  state_in   = ST_DECIDE;
               end else begin
                  sp_in    = side_val;
                  i_in     = '0;
                  state_in = ST_CUR_RD;
               end
            end
         end
         ST_DECIDE: begin
            num_in = NW'(sp_mag);
            den_in = side_diff[SW] ? NW'(-side_diff) : NW'(side_diff);
            priority if (cur_in != prev_in) state_in = ST_LX_GO;
            else if (cur_in)                state_in = ST_PUSH_CUR;
            else                            state_in = ST_NEXT;
         end
         ST_LX_GO: state_in = ST_LX_WAIT;
         ST_LX_WAIT: begin
            if (alu_stat.done) begin
               cross_x_in = alu_coord;
               state_in   = ST_LY_GO;
            end
         end
         ST_LY_GO: state_in = ST_LY_WAIT;
         ST_LY_WAIT: begin
            if (alu_stat.done) begin
               cross_y_in = alu_coord;
               state_in   = ST_PUSH_CROSS;
            end
         end
         ST_PUSH_CROSS: begin
            if (32'(m_ff) < MAX_OUTPUT) m_in = m_ff + NCW'(1);
            else                        ovf_in = 1'b1;
            state_in = cur_in ? ST_PUSH_CUR : ST_NEXT;
         end
         ST_PUSH_CUR: begin
            if (32'(m_ff) < MAX_OUTPUT) m_in = m_ff + NCW'(1);
            else                        ovf_in = 1'b1;
            state_in = ST_NEXT;
         end
         ST_NEXT: begin
            prev_x_in = cur_x_ff;
            prev_y_in = cur_y_ff;
            sp_in     = sc_side_ff;
            if (32'(i_ff) + 32'd1 == 32'(n_ff)) begin
               // pass done: destination half becomes the source
               n_in    = m_ff;
               bank_in = ~bank_ff;
               if (32'(j_ff) + 32'd1 == 32'(cc_ff) || m_ff == '0) begin
                  state_in = ST_EMIT_START;
               end else begin
                  j_in     = j_ff + CCW'(1);
                  state_in = ST_EDGE_S;
               end
            end else begin
               i_in     = i_ff + IW'(1);
               state_in = ST_CUR_RD;
            end
         end
         ST_EMIT_START: begin
            i_in = '0;
            if (n_ff == '0) begin
               rsp_in.out_x       = '0;
               rsp_in.out_y       = '0;
               rsp_in.last_vertex = 1'b1;
               rsp_in.status      = cpc_pkg::STATUS_EMPTY;
               state_in           = ST_EMIT_OUT;
            end else begin
               state_in = ST_EMIT_RD;
            end
         end
         ST_EMIT_RD: state_in = ST_EMIT_GET;
         ST_EMIT_GET: begin
            rsp_in.out_x       = sat_out(wrk_x);
            rsp_in.out_y       = sat_out(wrk_y);
            rsp_in.last_vertex = (32'(i_ff) + 32'd1 == emit_k);
            rsp_in.status      = (ovf_ff || more_than_limit) ? cpc_pkg::STATUS_OVERFLOW
                                                             : cpc_pkg::STATUS_VALID;
            state_in           = ST_EMIT_OUT;
         end
         ST_EMIT_OUT: begin
            if (!rsp_stall) begin
               if (rsp_ff.last_vertex) begin
                  state_in = ST_IDLE;
               end else begin
                  i_in     = i_ff + IW'(1);
                  state_in = ST_EMIT_RD;
               end
            end
         end
         default: state_in = ST_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
         sc_ff    <= '0;
         cc_ff    <= '0;
      end else begin
         state_ff <= state_in;
         sc_ff    <= sc_in;
         cc_ff    <= cc_in;
      end
      n_ff        <= n_in;
      m_ff        <= m_in;
      i_ff        <= i_in;
      j_ff        <= j_in;
      bank_ff     <= bank_in;
      ovf_ff      <= ovf_in;
      side_cur_ff <= side_cur_in;
      s_x_ff      <= s_x_in;
      s_y_ff      <= s_y_in;
      ex_ff       <= ex_in;
      ey_ff       <= ey_in;
      prev_x_ff   <= prev_x_in;
      prev_y_ff   <= prev_y_in;
      cur_x_ff    <= cur_x_in;
      cur_y_ff    <= cur_y_in;
      pxd_ff      <= pxd_in;
      pyd_ff      <= pyd_in;
      p1_ff       <= p1_in;
      sp_ff       <= sp_in;
      sc_side_ff  <= sc_side_in;
      num_ff      <= num_in;
      den_ff      <= den_in;
      cross_x_ff  <= cross_x_in;
      cross_y_ff  <= cross_y_in;
      rsp_ff      <= rsp_in;
   end

   assign req_stall = (state_ff != ST_IDLE);
   assign rsp_valid = (state_ff == ST_EMIT_OUT);
   assign rsp_data  = rsp_ff;

   cpc_ram #(.WIDTH(2 * CW), .DEPTH(MAX_SUBJECT)) u_subject_ram (
      .clock   (clock),
      .wr_en   (subj_we),
      .wr_addr (subj_wa),
      .wr_data (load_vtx),
      .rd_addr (subj_ra),
      .rd_data (subj_rd)
   );

   cpc_ram #(.WIDTH(2 * CW), .DEPTH(MAX_CLIP)) u_clip_ram (
      .clock   (clock),
      .wr_en   (clip_we),
      .wr_addr (clip_wa),
      .wr_data (load_vtx),
      .rd_addr (clip_ra),
      .rd_data (clip_rd)
   );

   // two halves: source and destination list of the current pass
   cpc_ram #(.WIDTH(2 * CW), .DEPTH(WORK_DEPTH)) u_work_ram (
      .clock   (clock),
      .wr_en   (work_we),
      .wr_addr (work_wa),
      .wr_data (work_wd),
      .rd_addr (work_ra),
      .rd_data (work_rd)
   );

   cpc_alu #(.COORD_WIDTH(CW)) u_alu (
      .clock (clock),
      .reset (reset),
      .ctl   (alu_ctl),
      .a     (alu_a),
      .b     (alu_b),
      .base  (alu_base),
      .num   (num_ff),
      .den   (den_ff),
      .stat  (alu_stat),
      .prod  (alu_prod),
      .coord (alu_coord)
   );

endmodule

### rtl/cpc_ram.sv
// generic single write, single registered read memory
module cpc_ram #(
   parameter int WIDTH = 64,
   parameter int DEPTH = 16,
   localparam int AW = $clog2(DEPTH)
) (
   input  logic             clock,
   input  logic             wr_en,
   input  logic [AW-1:0]    wr_addr,
   input  logic [WIDTH-1:0] wr_data,
   input  logic [AW-1:0]    rd_addr,
   output logic [WIDTH-1:0] rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      rd_data_ff <= mem_ff[rd_addr];
   end

   assign rd_data = rd_data_ff;

endmodule

### rtl/cpc_alu.sv
// shared bit-serial multiplier and interpolating divider
module cpc_alu #(
   parameter int COORD_WIDTH = cpc_pkg::COORD_WIDTH_DEF,
   localparam int CW = COORD_WIDTH,
   localparam int DW = CW + 1,
   localparam int PW = 2 * DW,
   localparam int NW = PW + 2
) (
   input  logic                   clock,
   input  logic                   reset,
   input  cpc_pkg::alu_ctl_type   ctl,
   input  logic signed [DW-1:0]   a,
   input  logic signed [DW-1:0]   b,
   input  logic signed [CW-1:0]   base,
   input  logic [NW-1:0]          num,
   input  logic [NW-1:0]          den,
   output cpc_pkg::alu_stat_type  stat,
   output logic signed [PW-1:0]   prod,
   output logic signed [CW-1:0]   coord
);

   localparam int CNTW = $clog2(DW + 1);

   logic                  busy_ff, busy_in;
   logic                  done_ff, done_in;
   cpc_pkg::alu_op_type   op_ff, op_in;
   logic [CNTW-1:0]       cnt_ff, cnt_in;
   logic                  neg_ff, neg_in;
   logic [PW-1:0]         mcand_ff, mcand_in;
   logic [DW-1:0]         mplier_ff, mplier_in;
   logic [PW-1:0]         acc_ff, acc_in;
   logic [NW-1:0]         rem_ff, rem_in;
   logic [NW-1:0]         num_ff, num_in;
   logic [NW-1:0]         den_ff, den_in;
   logic [DW:0]           q_ff, q_in;
   logic signed [CW-1:0]  base_ff, base_in;

   logic [DW-1:0] mag_a, mag_b;
   logic [NW+1:0] r2;
   logic [NW+2:0] t1, t2;

   assign mag_a = a[DW-1] ? DW'(-a) : DW'(a);
   assign mag_b = b[DW-1] ? DW'(-b) : DW'(b);

   always_comb begin
      r2 = (NW+2)'({rem_ff, 1'b0}) + (mplier_ff[DW-1] ? (NW+2)'(num_ff) : '0);
      t1 = (NW+3)'(r2) - (NW+3)'(den_ff);
      t2 = (NW+3)'(r2) - (NW+3)'({den_ff, 1'b0});
   end

   always_comb begin
      busy_in   = busy_ff;
      done_in   = 1'b0;
      op_in     = op_ff;
      cnt_in    = cnt_ff;
      neg_in    = neg_ff;
      mcand_in  = mcand_ff;
      mplier_in = mplier_ff;
      acc_in    = acc_ff;
      rem_in    = rem_ff;
      num_in    = num_ff;
      den_in    = den_ff;
      q_in      = q_ff;
      base_in   = base_ff;
      if (ctl.start) begin
         busy_in   = 1'b1;
         op_in     = ctl.op;
         cnt_in    = CNTW'(DW);
         neg_in    = (ctl.op == cpc_pkg::ALU_MUL) ? (a[DW-1] ^ b[DW-1]) : a[DW-1];
         mcand_in  = PW'(mag_b);
         mplier_in = mag_a;
         acc_in    = '0;
         rem_in    = '0;
         q_in      = '0;
         num_in    = num;
         den_in    = den;
         base_in   = base;
      end else if (busy_ff) begin
         unique case (op_ff)
            cpc_pkg::ALU_MUL: begin
               if (mplier_ff[0]) begin
                  acc_in = acc_ff + mcand_ff;
               end
               mcand_in  = {mcand_ff[PW-2:0], 1'b0};
               mplier_in = {1'b0, mplier_ff[DW-1:1]};
            end
            cpc_pkg::ALU_LERP: begin
               // remainder stays below den, so at most two subtractions
               priority if (!t2[NW+2]) begin
                  rem_in = t2[NW-1:0];
                  q_in   = {q_ff[DW-1:0], 1'b0} + (DW+1)'(2);
               end else if (!t1[NW+2]) begin
                  rem_in = t1[NW-1:0];
                  q_in   = {q_ff[DW-1:0], 1'b0} + (DW+1)'(1);
               end else begin
                  rem_in = r2[NW-1:0];
                  q_in   = {q_ff[DW-1:0], 1'b0};
               end
               mplier_in = {mplier_ff[DW-2:0], 1'b0};
            end
            default: ;
         endcase
         cnt_in = cnt_ff - CNTW'(1);
         if (cnt_ff == CNTW'(1)) begin
            busy_in = 1'b0;
            done_in = 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
      end else begin
         busy_ff <= busy_in;
         done_ff <= done_in;
      end
      op_ff     <= op_in;
      cnt_ff    <= cnt_in;
      neg_ff    <= neg_in;
      mcand_ff  <= mcand_in;
      mplier_ff <= mplier_in;
      acc_ff    <= acc_in;
      rem_ff    <= rem_in;
      num_ff    <= num_in;
      den_ff    <= den_in;
      q_ff      <= q_in;
      base_ff   <= base_in;
   end

   assign stat.busy = busy_ff;
   assign stat.done = done_ff;
   assign prod  = neg_ff ? PW'(-acc_ff) : PW'(acc_ff);
   assign coord = neg_ff ? CW'((CW+2)'(base_ff) - (CW+2)'(q_ff))
                         : CW'((CW+2)'(base_ff) + (CW+2)'(q_ff));

endmodule
